// ----- sv/cbc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cartridge bank controller package
// Shared types, codes and constants for the bank controller front end,
// access queue and back end.
// ----------------------------------------------------------------------------
package cbc_pkg;

    // Mapper type codes held in the configuration register.
    localparam logic [2:0] MAPPER_PLAIN = 3'd0;
    localparam logic [2:0] MAPPER_MBC1  = 3'd1;
    localparam logic [2:0] MAPPER_MBC2  = 3'd2;
    localparam logic [2:0] MAPPER_MBC3  = 3'd3;
    localparam logic [2:0] MAPPER_MBC5  = 3'd4;

    // Result target codes.
    typedef enum logic [2:0] {
        TGT_NONE   = 3'd0,
        TGT_ROM    = 3'd1,
        TGT_RAM_RD = 3'd2,
        TGT_RAM_WR = 3'd3,
        TGT_DIRECT = 3'd4
    } target_t;

    // Access class decided by the front end.
    typedef enum logic [2:0] {
        KIND_NONE,
        KIND_ROM_READ,
        KIND_CTRL_WRITE,
        KIND_WIN_READ,
        KIND_WIN_WRITE
    } kind_t;

    // One classified access as it travels through the queue.
    typedef struct packed {
        kind_t       kind;
        logic [15:0] addr;
        logic [7:0]  data;
    } item_t;

    // Queue status seen by the front and back ends.
    typedef struct packed {
        logic not_empty;
        logic full;
    } queue_status_t;

    // Clock register selects in the MBC3 RAM bank register.
    localparam logic [3:0] CLK_SEL_SEC  = 4'd8;
    localparam logic [3:0] CLK_SEL_MIN  = 4'd9;
    localparam logic [3:0] CLK_SEL_HOUR = 4'd10;
    localparam logic [3:0] CLK_SEL_DAYL = 4'd11;
    localparam logic [3:0] CLK_SEL_DAYH = 4'd12;

    // Low nibble that enables external RAM.
    localparam logic [3:0] RAM_ENABLE_KEY = 4'hA;

    // Reset value of the ROM bank register.
    localparam logic [8:0] ROM_BANK_RESET = 9'd1;

    // Read value when the RAM window is disabled.
    localparam logic [7:0] DISABLED_READ = 8'hFF;

endpackage

// ----- sv/cbc_in_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bank controller access channel
// Carries one CPU bus access per beat from the source to the controller.
// ----------------------------------------------------------------------------
interface cbc_in_if;
    logic        valid;
    logic        ready;
    logic [0:0]  opcode;
    logic [15:0] bus_address;
    logic [7:0]  write_byte_in;

    modport source (output valid, output opcode, output bus_address,
                    output write_byte_in, input ready);
    modport sink (input valid, input opcode, input bus_address,
                  input write_byte_in, output ready);
endinterface

// ----- sv/cbc_out_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bank controller result channel
// Carries one translated access result per beat to the memory side.
// ----------------------------------------------------------------------------
interface cbc_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  target;
    logic [22:0] memory_address;
    logic [7:0]  data_out;
    logic [0:0]  nibble_only;

    modport source (output valid, output target, output memory_address,
                    output data_out, output nibble_only, input ready);
    modport sink (input valid, input target, input memory_address,
                  input data_out, input nibble_only, output ready);
endinterface

// ----- sv/cbc_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bank controller front end
// Accepts bus access beats and classifies them by address region and
// direction before handing them to the access queue.
// ----------------------------------------------------------------------------
module cbc_front (
    cbc_in_if.sink               in_ch,
    input  cbc_pkg::queue_status_t q_status,
    output logic                 push,
    output cbc_pkg::item_t       push_item
);

    cbc_pkg::kind_t kind;

    // Accept whenever the queue has a free slot.
    assign in_ch.ready = !q_status.full;
    assign push        = in_ch.valid && !q_status.full;

    // Region decode: control and ROM space below 0x8000, RAM window at
    // 0xA000-0xBFFF, everything else is classed as no access (target none).
    always_comb
    begin
        if (!in_ch.bus_address[15]) begin
            kind = in_ch.opcode[0] ? cbc_pkg::KIND_CTRL_WRITE : cbc_pkg::KIND_ROM_READ;
        end else if (in_ch.bus_address[15:13] == 3'b101) begin
            kind = in_ch.opcode[0] ? cbc_pkg::KIND_WIN_WRITE : cbc_pkg::KIND_WIN_READ;
        end else begin
            kind = cbc_pkg::KIND_NONE;
        end
    end

    assign push_item.kind = kind;
    assign push_item.addr = in_ch.bus_address;
    assign push_item.data = in_ch.write_byte_in;

endmodule

// ----- sv/cbc_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bank controller access queue
// Two-entry queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module cbc_queue (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  cbc_pkg::item_t          push_item,
    input  logic                    pop,
    output cbc_pkg::item_t          head_item,
    output cbc_pkg::queue_status_t  status
);

    cbc_pkg::item_t mem_reg [2];
    logic           wr_ptr_reg;
    logic           wr_ptr_next;
    logic           rd_ptr_reg;
    logic           rd_ptr_next;
    logic [1:0]     count_reg;
    logic [1:0]     count_next;

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    assign head_item        = mem_reg[rd_ptr_reg];
    assign status.not_empty = (count_reg != 2'd0);
    assign status.full      = count_reg[1];

endmodule

// ----- sv/cbc_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bank controller back end
// Holds the bank, enable, mode and clock registers, carries out each
// queued access and registers its result on the output channel.
// ----------------------------------------------------------------------------
module cbc_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [2:0]             mapper_type,
    input  cbc_pkg::item_t         head_item,
    input  cbc_pkg::queue_status_t q_status,
    output logic                   pop,
    cbc_out_if.source              out_ch
);

    // Mapper state.
    logic [8:0] rom_bank_reg;
    logic [8:0] rom_bank_next;
    logic [3:0] ram_bank_reg;
    logic [3:0] ram_bank_next;
    logic       ram_enabled_reg;
    logic       ram_enabled_next;
    logic       rom_mode_reg;
    logic       rom_mode_next;
    logic [7:0] clk_sec_reg;
    logic [7:0] clk_sec_next;
    logic [7:0] clk_min_reg;
    logic [7:0] clk_min_next;
    logic [7:0] clk_hour_reg;
    logic [7:0] clk_hour_next;
    logic [8:0] clk_days_reg;
    logic [8:0] clk_days_next;
    logic       clk_halt_reg;
    logic       clk_halt_next;
    logic       clk_carry_reg;
    logic       clk_carry_next;

    // Output stage.
    logic             out_valid_reg;
    cbc_pkg::target_t out_target_reg;
    logic [22:0]      out_addr_reg;
    logic [7:0]       out_data_reg;
    logic             out_nib_reg;

    cbc_pkg::target_t res_target;
    logic [22:0]      res_addr;
    logic [7:0]       res_data;
    logic             res_nib;

    logic [15:0] a;
    logic [7:0]  v;
    logic [22:0] banked_addr;
    logic [22:0] window_off;
    logic [4:0]  mbc1_low;
    logic [6:0]  mbc3_bank;
    logic [6:0]  mbc1_high;
    logic [3:0]  mbc2_bank;
    logic [7:0]  clock_read;

    assign a = head_item.addr;
    assign v = head_item.data;

    // Take the next access when the output stage is free or being drained.
    assign pop = q_status.not_empty && (!out_valid_reg || out_ch.ready);

    // Window addresses: banked by the RAM bank, or the plain offset.
    assign banked_addr = {6'd0, ram_bank_reg, a[12:0]};
    assign window_off  = {10'd0, a[12:0]};

    // Bank values with the zero-bank substitution.
    assign mbc1_low  = (v[4:0] == 5'd0) ? 5'd1 : v[4:0];
    assign mbc3_bank = (v[6:0] == 7'd0) ? 7'd1 : v[6:0];
    assign mbc2_bank = (v[3:0] == 4'd0) ? 4'd1 : v[3:0];

    // MBC1 upper bank bits; banks 0x20, 0x40 and 0x60 step up by one.
    always_comb
    begin
        mbc1_high = {v[1:0], rom_bank_reg[4:0]};
        if (mbc1_high[4:0] == 5'd0 && mbc1_high[6:5] != 2'd0) begin
            mbc1_high = mbc1_high + 7'd1;
        end
    end

    // MBC3 clock register read.
    always_comb
    begin
        unique case (ram_bank_reg)
            cbc_pkg::CLK_SEL_SEC:  clock_read = clk_sec_reg;
            cbc_pkg::CLK_SEL_MIN:  clock_read = clk_min_reg;
            cbc_pkg::CLK_SEL_HOUR: clock_read = clk_hour_reg;
            cbc_pkg::CLK_SEL_DAYL: clock_read = clk_days_reg[7:0];
            cbc_pkg::CLK_SEL_DAYH:
                clock_read = {clk_carry_reg, clk_halt_reg, 5'd0, clk_days_reg[8]};
            default:               clock_read = 8'd0;
        endcase
    end

    // Carry out one access: result fields and next state.
    always_comb
    begin
        res_target       = cbc_pkg::TGT_NONE;
        res_addr         = 23'd0;
        res_data         = 8'd0;
        res_nib          = 1'b0;
        rom_bank_next    = rom_bank_reg;
        ram_bank_next    = ram_bank_reg;
        ram_enabled_next = ram_enabled_reg;
        rom_mode_next    = rom_mode_reg;
        clk_sec_next     = clk_sec_reg;
        clk_min_next     = clk_min_reg;
        clk_hour_next    = clk_hour_reg;
        clk_days_next    = clk_days_reg;
        clk_halt_next    = clk_halt_reg;
        clk_carry_next   = clk_carry_reg;

        case (head_item.kind)
            cbc_pkg::KIND_ROM_READ:
            begin
                res_target = cbc_pkg::TGT_ROM;
                res_addr   = a[14] ? {rom_bank_reg, a[13:0]} : {7'd0, a};
            end

            cbc_pkg::KIND_CTRL_WRITE:
            begin
                if (mapper_type == cbc_pkg::MAPPER_MBC2) begin
                    // Address bit 8 picks the enable or the ROM bank register.
                    if (!a[14]) begin
                        if (!a[8]) begin
                            ram_enabled_next = (v[3:0] == cbc_pkg::RAM_ENABLE_KEY);
                        end else begin
                            rom_bank_next = {5'd0, mbc2_bank};
                        end
                    end
                end else if (mapper_type == cbc_pkg::MAPPER_MBC1 ||
                             mapper_type == cbc_pkg::MAPPER_MBC3 ||
                             mapper_type == cbc_pkg::MAPPER_MBC5) begin
                    unique case (a[14:13])
                        2'd0: ram_enabled_next = (v[3:0] == cbc_pkg::RAM_ENABLE_KEY);
                        2'd1:
                        begin
                            if (mapper_type == cbc_pkg::MAPPER_MBC1) begin
                                rom_bank_next = {2'd0, rom_bank_reg[6:5], mbc1_low};
                            end else if (mapper_type == cbc_pkg::MAPPER_MBC3) begin
                                rom_bank_next = {2'd0, mbc3_bank};
                            end else if (!a[12]) begin
                                rom_bank_next = {rom_bank_reg[8], v};
                            end else begin
                                rom_bank_next = {v[0], rom_bank_reg[7:0]};
                            end
                        end
                        2'd2:
                        begin
                            if (mapper_type == cbc_pkg::MAPPER_MBC1) begin
                                if (rom_mode_reg) begin
                                    rom_bank_next = {2'd0, mbc1_high};
                                end else begin
                                    ram_bank_next = {2'd0, v[1:0]};
                                end
                            end else begin
                                ram_bank_next = v[3:0];
                            end
                        end
                        default:
                        begin
                            if (mapper_type == cbc_pkg::MAPPER_MBC1) begin
                                rom_mode_next = !v[0];
                            end
                        end
                    endcase
                end
            end

            cbc_pkg::KIND_WIN_READ,
            cbc_pkg::KIND_WIN_WRITE:
            begin
                if (!ram_enabled_reg) begin
                    // Disabled RAM reads as all ones; writes are dropped.
                    if (head_item.kind == cbc_pkg::KIND_WIN_READ) begin
                        res_target = cbc_pkg::TGT_DIRECT;
                        res_data   = cbc_pkg::DISABLED_READ;
                    end
                end else if (mapper_type == cbc_pkg::MAPPER_MBC1 ||
                             mapper_type == cbc_pkg::MAPPER_MBC5 ||
                             (mapper_type == cbc_pkg::MAPPER_MBC3 &&
                              ram_bank_reg[3:2] == 2'd0)) begin
                    res_addr = banked_addr;
                    if (head_item.kind == cbc_pkg::KIND_WIN_WRITE) begin
                        res_target = cbc_pkg::TGT_RAM_WR;
                        res_data   = v;
                    end else begin
                        res_target = cbc_pkg::TGT_RAM_RD;
                    end
                end else if (mapper_type == cbc_pkg::MAPPER_MBC3) begin
                    // Clock registers and unmapped banks.
                    if (head_item.kind == cbc_pkg::KIND_WIN_WRITE) begin
                        unique case (ram_bank_reg)
                            cbc_pkg::CLK_SEL_SEC:  clk_sec_next = v;
                            cbc_pkg::CLK_SEL_MIN:  clk_min_next = v;
                            cbc_pkg::CLK_SEL_HOUR: clk_hour_next = v;
                            cbc_pkg::CLK_SEL_DAYL: clk_days_next = {clk_days_reg[8], v};
                            cbc_pkg::CLK_SEL_DAYH:
                            begin
                                clk_days_next  = {v[0], clk_days_reg[7:0]};
                                clk_halt_next  = v[6];
                                clk_carry_next = v[7];
                            end
                            default: ;
                        endcase
                    end else begin
                        res_target = cbc_pkg::TGT_DIRECT;
                        res_data   = clock_read;
                    end
                end else if (mapper_type == cbc_pkg::MAPPER_MBC2) begin
                    // 512 nibbles; above them reads give zero.
                    if (a[12:9] == 4'd0) begin
                        res_addr = window_off;
                        if (head_item.kind == cbc_pkg::KIND_WIN_WRITE) begin
                            res_target = cbc_pkg::TGT_RAM_WR;
                            res_data   = {4'd0, v[3:0]};
                        end else begin
                            res_target = cbc_pkg::TGT_RAM_RD;
                            res_nib    = 1'b1;
                        end
                    end else if (head_item.kind == cbc_pkg::KIND_WIN_READ) begin
                        res_target = cbc_pkg::TGT_DIRECT;
                    end
                end else begin
                    // Unbanked window for plain ROM and unknown types.
                    res_addr = window_off;
                    if (head_item.kind == cbc_pkg::KIND_WIN_WRITE) begin
                        res_target = cbc_pkg::TGT_RAM_WR;
                        res_data   = v;
                    end else begin
                        res_target = cbc_pkg::TGT_RAM_RD;
                    end
                end
            end

            default: ;
        endcase
    end

    // State registers advance only when an access is carried out.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            rom_bank_reg    <= cbc_pkg::ROM_BANK_RESET;
            ram_bank_reg    <= 4'd0;
            ram_enabled_reg <= 1'b0;
            rom_mode_reg    <= 1'b1;
            clk_sec_reg     <= 8'd0;
            clk_min_reg     <= 8'd0;
            clk_hour_reg    <= 8'd0;
            clk_days_reg    <= 9'd0;
            clk_halt_reg    <= 1'b0;
            clk_carry_reg   <= 1'b0;
        end else if (pop) begin
            rom_bank_reg    <= rom_bank_next;
            ram_bank_reg    <= ram_bank_next;
            ram_enabled_reg <= ram_enabled_next;
            rom_mode_reg    <= rom_mode_next;
            clk_sec_reg     <= clk_sec_next;
            clk_min_reg     <= clk_min_next;
            clk_hour_reg    <= clk_hour_next;
            clk_days_reg    <= clk_days_next;
            clk_halt_reg    <= clk_halt_next;
            clk_carry_reg   <= clk_carry_next;
        end
    end

    // Output valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else if (pop) begin
            out_valid_reg <= 1'b1;
        end else if (out_ch.ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output payload.
    always_ff @(posedge clk)
    begin
        if (pop) begin
            out_target_reg <= res_target;
            out_addr_reg   <= res_addr;
            out_data_reg   <= res_data;
            out_nib_reg    <= res_nib;
        end
    end

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.target         = out_target_reg;
    assign out_ch.memory_address = out_addr_reg;
    assign out_ch.data_out       = out_data_reg;
    assign out_ch.nibble_only    = out_nib_reg;

endmodule

// ----- sv/cartridge_bank_controller_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cartridge bank controller
// Maps CPU bus accesses to the cartridge space onto ROM and RAM addresses
// for plain ROM, MBC1, MBC2, MBC3 and MBC5 cartridges.
// ----------------------------------------------------------------------------
// Usage:
// The access channel takes one bus access per beat (opcode, address, write
// byte). Every access produces exactly one beat on the result channel, in
// order: a ROM or RAM address, a RAM write with its data, a direct read
// value, or a target of none. The mapper type is written through
// cfg_write_en and cfg_write_data while no access is in flight.
// An accepted access beat is written into the queue, then its result is
// registered in the output stage that drives the result channel.
// Throughput is one access per cycle while the result channel does not stall,
// set by the single back-end stage that updates the bank registers.
// A two-entry queue sits between the front-end decode and the back end,
// and a registered output stage holds a result while the receiver stalls;
// the access channel keeps accepting until the queue is full.
// Reset clears the queue and output stage, selects plain ROM, sets the ROM
// bank to one with ROM banking mode, disables RAM and zeroes the clock.
// ----------------------------------------------------------------------------
module cartridge_bank_controller_unit (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_write_en,
    input  logic [2:0] cfg_write_data,
    cbc_in_if.sink     in_ch,
    cbc_out_if.source  out_ch
);

    logic [2:0]             mapper_type_reg;
    logic                   push;
    logic                   pop;
    cbc_pkg::item_t         push_item;
    cbc_pkg::item_t         head_item;
    cbc_pkg::queue_status_t q_status;

    // Mapper type register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mapper_type_reg <= cbc_pkg::MAPPER_PLAIN;
        end
        else if (cfg_write_en)
        begin
            mapper_type_reg <= cfg_write_data;
        end
    end

    cbc_front u_front (
        .in_ch     (in_ch),
        .q_status  (q_status),
        .push      (push),
        .push_item (push_item)
    );

    cbc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head_item (head_item),
        .status    (q_status)
    );

    cbc_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .mapper_type (mapper_type_reg),
        .head_item   (head_item),
        .q_status    (q_status),
        .pop         (pop),
        .out_ch      (out_ch)
    );

endmodule

// ----- bench/cartridge_bank_controller_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cartridge bank controller testbench
// Drives CPU bus accesses into the controller under every mapper type and
// checks each result beat against a cycle-free model of the bank registers,
// the RAM window and the MBC3 clock registers. A short directed sequence
// covers the corner cases, then random phases under random flow control.
// ----------------------------------------------------------------------------
module cartridge_bank_controller_unit_tb;
    import cbc_pkg::*;

    localparam int CYCLE_LIMIT  = 600000;
    localparam int PHASE_ITEMS  = 165;
    localparam int RANDOM_PHASES = 10;

    // Control regions of the 0x0000-0x7FFF write space (address bits 14:13).
    localparam logic [1:0] RGN_RAM_ENABLE = 2'd0;
    localparam logic [1:0] RGN_ROM_BANK   = 2'd1;
    localparam logic [1:0] RGN_RAM_BANK   = 2'd2;
    localparam logic [1:0] RGN_MODE       = 2'd3;

    // Window select bits 15:13 for 0xA000-0xBFFF.
    localparam logic [2:0] WINDOW_SEL = 3'b101;

    typedef struct packed {
        logic        wr;
        logic [15:0] addr;
        logic [7:0]  data;
    } bus_access_t;

    typedef struct packed {
        target_t     target;
        logic [22:0] addr;
        logic [7:0]  data;
        logic        nib;
    } bus_result_t;

    logic       clk;
    logic       rst_n;
    logic       cfg_write_en;
    logic [2:0] cfg_write_data;

    cbc_in_if  acc_ch ();
    cbc_out_if res_ch ();

    cartridge_bank_controller_unit uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .in_ch          (acc_ch),
        .out_ch         (res_ch)
    );

    // Model copy of the mapper configuration and bank state.
    logic [2:0] mapper_sel;
    logic [8:0] rom_bank_q;
    logic [3:0] ram_bank_q;
    logic       ram_on;
    logic       rom_mode;
    logic [7:0] rtc_sec;
    logic [7:0] rtc_min;
    logic [7:0] rtc_hour;
    logic [8:0] rtc_day;
    logic       rtc_halt;
    logic       rtc_carry;

    bus_access_t access_queue[$];
    bus_result_t pending_results[$];

    int  fail_count;
    int  cycle_count;
    bit  quiet_in;
    bit  quiet_out;
    int  in_gap;
    int  out_stall;

    // Clock generation.
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Gap length for either side: mostly short, a few long.
    function automatic int draw_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    // Translate one bus access and update the bank and clock registers.
    function automatic bus_result_t translate_access(input bus_access_t acc);
        bus_result_t r;
        logic [15:0] off;
        logic [16:0] banked;
        logic [4:0]  low5;
        logic [6:0]  low7;
        logic [8:0]  nb;
        r.target = TGT_NONE;
        r.addr   = '0;
        r.data   = '0;
        r.nib    = 1'b0;
        off      = acc.addr - 16'hA000;
        banked   = {ram_bank_q, off[12:0]};

        if (!acc.addr[15]) begin
            if (!acc.wr) begin
                // ROM read: fixed bank below 0x4000, switched bank above.
                r.target = TGT_ROM;
                if (!acc.addr[14])
                    r.addr = {7'd0, acc.addr};
                else
                    r.addr = {rom_bank_q, acc.addr[13:0]};
            end
            else if (mapper_sel == MAPPER_MBC2) begin
                // MBC2 registers live below 0x4000; address bit 8 selects.
                if (!acc.addr[14]) begin
                    if (!acc.addr[8])
                        ram_on = (acc.data[3:0] == RAM_ENABLE_KEY);
                    else if (acc.data[3:0] == 4'd0)
                        rom_bank_q = ROM_BANK_RESET;
                    else
                        rom_bank_q = {5'd0, acc.data[3:0]};
                end
            end
            else if (mapper_sel == MAPPER_MBC1 || mapper_sel == MAPPER_MBC3 ||
                     mapper_sel == MAPPER_MBC5) begin
                case (acc.addr[14:13])
                    RGN_RAM_ENABLE:
                    begin
                        ram_on = (acc.data[3:0] == RAM_ENABLE_KEY);
                    end
                    RGN_ROM_BANK:
                    begin
                        if (mapper_sel == MAPPER_MBC1) begin
                            low5 = (acc.data[4:0] == 5'd0) ? 5'd1 : acc.data[4:0];
                            rom_bank_q = {2'b00, rom_bank_q[6:5], low5};
                        end
                        else if (mapper_sel == MAPPER_MBC3) begin
                            low7 = (acc.data[6:0] == 7'd0) ? 7'd1 : acc.data[6:0];
                            rom_bank_q = {2'b00, low7};
                        end
                        else if (!acc.addr[12])
                            rom_bank_q[7:0] = acc.data;
                        else
                            rom_bank_q[8] = acc.data[0];
                    end
                    RGN_RAM_BANK:
                    begin
                        if (mapper_sel != MAPPER_MBC1)
                            ram_bank_q = acc.data[3:0];
                        else if (rom_mode) begin
                            // Banks 0x20, 0x40 and 0x60 are skipped upward.
                            nb = {2'b00, acc.data[1:0], rom_bank_q[4:0]};
                            if (nb == 9'h020 || nb == 9'h040 || nb == 9'h060)
                                nb = nb + 9'd1;
                            rom_bank_q = nb;
                        end
                        else
                            ram_bank_q = {2'b00, acc.data[1:0]};
                    end
                    RGN_MODE:
                    begin
                        if (mapper_sel == MAPPER_MBC1)
                            rom_mode = !acc.data[0];
                    end
                endcase
            end
        end
        else if (acc.addr[15:13] != WINDOW_SEL) begin
            r.target = TGT_NONE;
        end
        else if (!ram_on) begin
            // Disabled window: reads see open bus, writes vanish.
            if (!acc.wr) begin
                r.target = TGT_DIRECT;
                r.data   = DISABLED_READ;
            end
        end
        else if (mapper_sel == MAPPER_MBC1 || mapper_sel == MAPPER_MBC5) begin
            r.target = acc.wr ? TGT_RAM_WR : TGT_RAM_RD;
            r.addr   = {6'd0, banked};
            r.data   = acc.wr ? acc.data : 8'd0;
        end
        else if (mapper_sel == MAPPER_MBC2) begin
            // 512 nibbles; the rest of the window reads zero.
            if (off[12:9] == 4'd0) begin
                r.target = acc.wr ? TGT_RAM_WR : TGT_RAM_RD;
                r.addr   = {7'd0, off};
                r.data   = acc.wr ? {4'd0, acc.data[3:0]} : 8'd0;
                r.nib    = !acc.wr;
            end
            else if (!acc.wr)
                r.target = TGT_DIRECT;
        end
        else if (mapper_sel == MAPPER_MBC3) begin
            if (ram_bank_q < 4'd4) begin
                r.target = acc.wr ? TGT_RAM_WR : TGT_RAM_RD;
                r.addr   = {6'd0, banked};
                r.data   = acc.wr ? acc.data : 8'd0;
            end
            else if (acc.wr) begin
                // Clock register writes produce no memory access.
                case (ram_bank_q)
                    CLK_SEL_SEC:  rtc_sec  = acc.data;
                    CLK_SEL_MIN:  rtc_min  = acc.data;
                    CLK_SEL_HOUR: rtc_hour = acc.data;
                    CLK_SEL_DAYL: rtc_day[7:0] = acc.data;
                    CLK_SEL_DAYH:
                    begin
                        rtc_day[8] = acc.data[0];
                        rtc_halt   = acc.data[6];
                        rtc_carry  = acc.data[7];
                    end
                    default: ;
                endcase
            end
            else begin
                r.target = TGT_DIRECT;
                case (ram_bank_q)
                    CLK_SEL_SEC:  r.data = rtc_sec;
                    CLK_SEL_MIN:  r.data = rtc_min;
                    CLK_SEL_HOUR: r.data = rtc_hour;
                    CLK_SEL_DAYL: r.data = rtc_day[7:0];
                    CLK_SEL_DAYH: r.data = {rtc_carry, rtc_halt, 5'd0, rtc_day[8]};
                    default:      r.data = 8'd0;
                endcase
            end
        end
        else begin
            // Plain ROM and unknown types: unbanked window.
            r.target = acc.wr ? TGT_RAM_WR : TGT_RAM_RD;
            r.addr   = {7'd0, off};
            r.data   = acc.wr ? acc.data : 8'd0;
        end
        return r;
    endfunction

    // Random access, shaped so that most traffic lands on live registers.
    function automatic bus_access_t make_access(input logic [2:0] mapper);
        bus_access_t acc;
        int          kind;
        logic [1:0]  rgn;
        logic [3:0]  sel;
        kind     = $urandom_range(0, 99);
        acc.wr   = 1'b0;
        acc.addr = 16'($urandom);
        acc.data = 8'($urandom);
        if (kind < 28) begin
            rgn      = 2'($urandom);
            acc.wr   = 1'b1;
            acc.addr = {1'b0, rgn, 13'($urandom)};
            if (rgn == RGN_RAM_ENABLE && $urandom_range(0, 3) != 0)
                acc.data[3:0] = RAM_ENABLE_KEY;
            else if (rgn == RGN_RAM_BANK && $urandom_range(0, 9) < 7) begin
                sel = 4'($urandom_range(0, 8));
                acc.data[3:0] = (sel < 4'd4) ? sel : sel + 4'd4;
            end
        end
        else if (kind < 50) begin
            acc.addr = {1'b0, 15'($urandom)};
        end
        else if (kind < 90) begin
            acc.wr   = 1'($urandom);
            acc.addr = {WINDOW_SEL, 13'($urandom)};
            if (mapper == MAPPER_MBC2 && $urandom_range(0, 1) == 0)
                acc.addr = 16'hA000 + 16'($urandom_range(0, 511));
        end
        else begin
            acc.wr = 1'($urandom);
        end
        return acc;
    endfunction

    task automatic push_access(input logic wr, input logic [15:0] addr,
                               input logic [7:0] data);
        bus_access_t acc;
        acc.wr   = wr;
        acc.addr = addr;
        acc.data = data;
        access_queue.push_back(acc);
    endtask

    // Wait until every access has been sent and every result checked.
    task automatic drain();
        while (access_queue.size() != 0 || pending_results.size() != 0 || acc_ch.valid)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Mapper type write while the controller is idle.
    task automatic set_mapper(input logic [2:0] m);
        @(posedge clk);
        cfg_write_en   <= 1'b1;
        cfg_write_data <= m;
        @(posedge clk);
        cfg_write_en   <= 1'b0;
        mapper_sel = m;
        @(negedge clk);
        quiet_in  = ($urandom_range(0, 3) == 0);
        quiet_out = ($urandom_range(0, 3) == 0);
    endtask

    // Access driver: holds each beat until it is taken, then idles at random.
    always @(posedge clk)
    begin
        bus_result_t res;
        if (!rst_n) begin
            acc_ch.valid <= 1'b0;
        end
        else begin
            if (acc_ch.valid && acc_ch.ready) begin
                res = translate_access(access_queue.pop_front());
                pending_results.push_back(res);
                in_gap = quiet_in ? 0 : draw_gap();
            end
            if (acc_ch.valid && !acc_ch.ready) begin
                // Beat still pending: hold it.
            end
            else if (in_gap > 0) begin
                in_gap--;
                acc_ch.valid <= 1'b0;
            end
            else if (access_queue.size() != 0) begin
                acc_ch.valid         <= 1'b1;
                acc_ch.opcode        <= access_queue[0].wr;
                acc_ch.bus_address   <= access_queue[0].addr;
                acc_ch.write_byte_in <= access_queue[0].data;
            end
            else
                acc_ch.valid <= 1'b0;
        end
    end

    // Result monitor: checks each taken beat and stalls the result side.
    always @(posedge clk)
    begin
        bus_result_t want;
        if (res_ch.valid && res_ch.ready) begin
            if (pending_results.size() == 0) begin
                $error("result beat with no access waiting: target %0d", res_ch.target);
                fail_count++;
            end
            else begin
                want = pending_results.pop_front();
                if (res_ch.target !== want.target) begin
                    $error("target: expected %0d, actual %0d", want.target, res_ch.target);
                    fail_count++;
                end
                if (res_ch.memory_address !== want.addr) begin
                    $error("memory_address: expected %h, actual %h",
                           want.addr, res_ch.memory_address);
                    fail_count++;
                end
                if (res_ch.data_out !== want.data) begin
                    $error("data_out: expected %h, actual %h", want.data, res_ch.data_out);
                    fail_count++;
                end
                if (res_ch.nibble_only !== want.nib) begin
                    $error("nibble_only: expected %0d, actual %0d",
                           want.nib, res_ch.nibble_only);
                    fail_count++;
                end
            end
            out_stall = quiet_out ? 0 : draw_gap();
        end
        if (rst_n && out_stall > 0) begin
            out_stall--;
            res_ch.ready <= 1'b0;
        end
        else
            res_ch.ready <= 1'b1;
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin
        int p;
        int i;
        logic [2:0] m;
        clk                  = 1'b0;
        rst_n                = 1'b0;
        cfg_write_en         = 1'b0;
        cfg_write_data       = MAPPER_PLAIN;
        acc_ch.valid         = 1'b0;
        acc_ch.opcode        = 1'b0;
        acc_ch.bus_address   = '0;
        acc_ch.write_byte_in = '0;
        res_ch.ready         = 1'b0;
        fail_count           = 0;
        cycle_count          = 0;
        quiet_in             = 1'b0;
        quiet_out            = 1'b0;
        in_gap               = 0;
        out_stall            = 0;

        // Model state after reset.
        mapper_sel = MAPPER_PLAIN;
        rom_bank_q = ROM_BANK_RESET;
        ram_bank_q = '0;
        ram_on     = 1'b0;
        rom_mode   = 1'b1;
        rtc_sec    = '0;
        rtc_min    = '0;
        rtc_hour   = '0;
        rtc_day    = '0;
        rtc_halt   = 1'b0;
        rtc_carry  = 1'b0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Plain ROM: both ROM ends, ignored control write, disabled window.
        set_mapper(MAPPER_PLAIN);
        push_access(1'b0, 16'h0000, 8'h00);
        push_access(1'b0, 16'h7FFF, 8'hFF);
        push_access(1'b1, 16'h2000, 8'hFF);
        push_access(1'b0, 16'hBFFF, 8'h00);
        push_access(1'b0, 16'hFFFF, 8'h00);
        drain();

        // MBC3: bank zero maps to one, clock registers, unused selects, a 0x6000 write.
        set_mapper(MAPPER_MBC3);
        push_access(1'b1, 16'h0000, 8'h0A);
        push_access(1'b1, 16'h2000, 8'h00);
        push_access(1'b1, 16'h3FFF, 8'hC0);
        push_access(1'b1, 16'h4000, 8'h08);
        push_access(1'b1, 16'hA000, 8'hFF);
        push_access(1'b0, 16'hBFFF, 8'h00);
        push_access(1'b1, 16'h5FFF, 8'h0C);
        push_access(1'b1, 16'hA000, 8'hC1);
        push_access(1'b0, 16'hA123, 8'h00);
        push_access(1'b1, 16'h4000, 8'h05);
        push_access(1'b0, 16'hA000, 8'h00);
        push_access(1'b1, 16'h6000, 8'h01);
        push_access(1'b1, 16'h4000, 8'h03);
        push_access(1'b0, 16'hBFFF, 8'h00);
        drain();

        // MBC1: high bank bits raise 0x20 by one, then RAM mode bank select.
        set_mapper(MAPPER_MBC1);
        push_access(1'b1, 16'h4000, 8'h01);
        push_access(1'b0, 16'h4000, 8'h00);
        push_access(1'b1, 16'h7FFF, 8'h01);
        push_access(1'b1, 16'h4000, 8'hFF);
        push_access(1'b1, 16'hA000, 8'h55);
        drain();

        // MBC2: bit 8 register select, nibble RAM and the dead upper window.
        set_mapper(MAPPER_MBC2);
        push_access(1'b1, 16'h0100, 8'h00);
        push_access(1'b1, 16'hA1FF, 8'hFF);
        push_access(1'b0, 16'hA200, 8'h00);
        push_access(1'b0, 16'hA000, 8'h00);
        push_access(1'b1, 16'h0000, 8'h0B);
        drain();

        // MBC5: full 9-bit ROM bank reaches the top of the address space.
        set_mapper(MAPPER_MBC5);
        push_access(1'b1, 16'h0000, 8'h0A);
        push_access(1'b1, 16'h2000, 8'hFF);
        push_access(1'b1, 16'h3000, 8'h01);
        push_access(1'b0, 16'h7FFF, 8'h00);
        push_access(1'b0, 16'hBFFF, 8'h00);
        drain();

        // Random phases, each mapper type twice.
        for (p = 0; p < RANDOM_PHASES; p++) begin
            m = 3'((p * 3 + 1) % 5);
            set_mapper(m);
            for (i = 0; i < PHASE_ITEMS; i++)
                access_queue.push_back(make_access(m));
            drain();
        end

        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
